### src/lbcm_pkg.sv
// Shared types and constants for the letterbox coordinate mapper.
// Holds field widths, operation and register codes, and the configuration struct.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lbcm_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int FRAC_BITS_DEFAULT  = 16;

    localparam int OP_W        = 3;
    localparam int LOG_W       = 13;
    localparam int PHYS_W      = 14;
    localparam int VIEW_W      = 13;
    localparam int SCALE_W     = 24;
    localparam int OUT_W       = 13;
    localparam int EXACT_W     = 28;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [OUT_W-1:0]  PHYS_BOUND_MAX = 13'd8191;
    localparam logic [PHYS_W-1:0] PHYS_SIZE_SAT  = 14'd8192;

    localparam logic [LOG_W-1:0]  RESET_LOGICAL_WIDTH   = 13'd640;
    localparam logic [LOG_W-1:0]  RESET_LOGICAL_HEIGHT  = 13'd480;
    localparam logic [PHYS_W-1:0] RESET_PHYSICAL_WIDTH  = 14'd640;
    localparam logic [PHYS_W-1:0] RESET_PHYSICAL_HEIGHT = 14'd480;
    localparam logic [VIEW_W-1:0] RESET_VIEWPORT_LEFT   = 13'd0;
    localparam logic [VIEW_W-1:0] RESET_VIEWPORT_TOP    = 13'd0;

    typedef enum logic [OP_W-1:0] {
        OP_LPOINT_TO_PHYS = 3'd0,
        OP_PPOINT_TO_LOG  = 3'd1,
        OP_LRECT_TO_PHYS  = 3'd2,
        OP_PRECT_TO_LOG   = 3'd3,
        OP_VIRTUAL_MAP    = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOGICAL_WIDTH   = 3'd0,
        REG_LOGICAL_HEIGHT  = 3'd1,
        REG_PHYSICAL_WIDTH  = 3'd2,
        REG_PHYSICAL_HEIGHT = 3'd3,
        REG_VIEWPORT_LEFT   = 3'd4,
        REG_VIEWPORT_TOP    = 3'd5,
        REG_SCALE           = 3'd6,
        REG_INV_SCALE       = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [SCALE_W-1:0] inv_scale;
        logic [VIEW_W-1:0]  view_left;
        logic [VIEW_W-1:0]  view_top;
        logic [OUT_W-1:0]   log_bound_x;
        logic [OUT_W-1:0]   log_bound_y;
        logic [OUT_W-1:0]   phys_bound_x;
        logic [OUT_W-1:0]   phys_bound_y;
    } cfg_t;

endpackage

`default_nettype wire

### src/lbcm_req_if.sv
// Request channel of the letterbox coordinate mapper: valid, ready and the request fields.
// Depends on lbcm_pkg for the operation width.
`default_nettype none

interface lbcm_req_if #(
    parameter int COORD_BITS = lbcm_pkg::COORD_BITS_DEFAULT
);
    import lbcm_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              operation;
    logic signed [COORD_BITS-1:0] in_left;
    logic signed [COORD_BITS-1:0] in_top;
    logic signed [COORD_BITS-1:0] in_right;
    logic signed [COORD_BITS-1:0] in_bottom;

    modport source (
        output valid, operation, in_left, in_top, in_right, in_bottom,
        input  ready
    );

    modport sink (
        input  valid, operation, in_left, in_top, in_right, in_bottom,
        output ready
    );

endinterface

`default_nettype wire

### src/lbcm_rsp_if.sv
// Result channel of the letterbox coordinate mapper: valid, ready and the result fields.
// Depends on lbcm_pkg for the field widths.
`default_nettype none

interface lbcm_rsp_if;
    import lbcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [OUT_W-1:0]   out_left;
    logic [OUT_W-1:0]   out_top;
    logic [OUT_W-1:0]   out_right;
    logic [OUT_W-1:0]   out_bottom;
    logic [EXACT_W-1:0] exact_x;
    logic [EXACT_W-1:0] exact_y;
    logic               inside_viewport;
    logic               clamped_low_x;
    logic               clamped_high_x;
    logic               clamped_low_y;
    logic               clamped_high_y;

    modport source (
        output valid, out_left, out_top, out_right, out_bottom, exact_x, exact_y,
               inside_viewport, clamped_low_x, clamped_high_x, clamped_low_y,
               clamped_high_y,
        input  ready
    );

    modport sink (
        input  valid, out_left, out_top, out_right, out_bottom, exact_x, exact_y,
               inside_viewport, clamped_low_x, clamped_high_x, clamped_low_y,
               clamped_high_y,
        output ready
    );

endinterface

`default_nettype wire

### src/lbcm_config.sv
// Configuration registers of the letterbox coordinate mapper and the bounds derived from them.
// Depends on lbcm_pkg for register codes, widths and the cfg_t struct.
`default_nettype none

module lbcm_config #(
    parameter int FRAC_BITS = lbcm_pkg::FRAC_BITS_DEFAULT,
    localparam int EXT_W = lbcm_pkg::LOG_W + lbcm_pkg::SCALE_W + 1 - FRAC_BITS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write,
    input  wire [lbcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [lbcm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output lbcm_pkg::cfg_t                     cfg,
    output logic [EXT_W-1:0]                   ext_x,
    output logic [EXT_W-1:0]                   ext_y
);
    import lbcm_pkg::*;

    localparam int EXT_SUM_W = LOG_W + SCALE_W + 1;

    logic [LOG_W-1:0]   log_width_reg;
    logic [LOG_W-1:0]   log_height_reg;
    logic [PHYS_W-1:0]  phys_width_reg;
    logic [PHYS_W-1:0]  phys_height_reg;
    logic [VIEW_W-1:0]  view_left_reg;
    logic [VIEW_W-1:0]  view_top_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [SCALE_W-1:0] inv_scale_reg;

    logic [OUT_W-1:0]   log_bound_x_reg;
    logic [OUT_W-1:0]   log_bound_y_reg;
    logic [OUT_W-1:0]   phys_bound_x_reg;
    logic [OUT_W-1:0]   phys_bound_y_reg;
    logic [EXT_W-1:0]   ext_x_reg;
    logic [EXT_W-1:0]   ext_y_reg;

    logic [OUT_W-1:0]     log_bound_x_next;
    logic [OUT_W-1:0]     log_bound_y_next;
    logic [OUT_W-1:0]     phys_bound_x_next;
    logic [OUT_W-1:0]     phys_bound_y_next;
    logic [EXT_W-1:0]     ext_x_next;
    logic [EXT_W-1:0]     ext_y_next;
    logic [EXT_SUM_W-1:0] ext_sum_x;
    logic [EXT_SUM_W-1:0] ext_sum_y;
    logic [EXT_SUM_W-1:0] half_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_width_reg   <= RESET_LOGICAL_WIDTH;
            log_height_reg  <= RESET_LOGICAL_HEIGHT;
            phys_width_reg  <= RESET_PHYSICAL_WIDTH;
            phys_height_reg <= RESET_PHYSICAL_HEIGHT;
            view_left_reg   <= RESET_VIEWPORT_LEFT;
            view_top_reg    <= RESET_VIEWPORT_TOP;
            scale_reg       <= SCALE_W'(1) << FRAC_BITS;
            inv_scale_reg   <= SCALE_W'(1) << FRAC_BITS;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LOGICAL_WIDTH:   log_width_reg   <= cfg_data[LOG_W-1:0];
                REG_LOGICAL_HEIGHT:  log_height_reg  <= cfg_data[LOG_W-1:0];
                REG_PHYSICAL_WIDTH:  phys_width_reg  <= cfg_data[PHYS_W-1:0];
                REG_PHYSICAL_HEIGHT: phys_height_reg <= cfg_data[PHYS_W-1:0];
                REG_VIEWPORT_LEFT:   view_left_reg   <= cfg_data[VIEW_W-1:0];
                REG_VIEWPORT_TOP:    view_top_reg    <= cfg_data[VIEW_W-1:0];
                REG_SCALE:           scale_reg       <= cfg_data[SCALE_W-1:0];
                REG_INV_SCALE:       inv_scale_reg   <= cfg_data[SCALE_W-1:0];
                default:             ;
            endcase
        end
    end

    // The viewport extent rounds the scaled logical size and never drops below one pixel.
    always_comb
    begin
        half_q    = EXT_SUM_W'(1) << (FRAC_BITS - 1);
        ext_sum_x = EXT_SUM_W'(log_width_reg) * EXT_SUM_W'(scale_reg) + half_q;
        ext_sum_y = EXT_SUM_W'(log_height_reg) * EXT_SUM_W'(scale_reg) + half_q;
        ext_x_next = ext_sum_x[EXT_SUM_W-1:FRAC_BITS];
        ext_y_next = ext_sum_y[EXT_SUM_W-1:FRAC_BITS];
        if (ext_x_next == '0)
        begin
            ext_x_next = EXT_W'(1);
        end
        if (ext_y_next == '0)
        begin
            ext_y_next = EXT_W'(1);
        end

        log_bound_x_next = (log_width_reg == '0) ? '0 : log_width_reg - LOG_W'(1);
        log_bound_y_next = (log_height_reg == '0) ? '0 : log_height_reg - LOG_W'(1);

        if (phys_width_reg == '0)
        begin
            phys_bound_x_next = '0;
        end
        else if (phys_width_reg > PHYS_SIZE_SAT)
        begin
            phys_bound_x_next = PHYS_BOUND_MAX;
        end
        else
        begin
            phys_bound_x_next = OUT_W'(phys_width_reg - PHYS_W'(1));
        end

        if (phys_height_reg == '0)
        begin
            phys_bound_y_next = '0;
        end
        else if (phys_height_reg > PHYS_SIZE_SAT)
        begin
            phys_bound_y_next = PHYS_BOUND_MAX;
        end
        else
        begin
            phys_bound_y_next = OUT_W'(phys_height_reg - PHYS_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        log_bound_x_reg  <= log_bound_x_next;
        log_bound_y_reg  <= log_bound_y_next;
        phys_bound_x_reg <= phys_bound_x_next;
        phys_bound_y_reg <= phys_bound_y_next;
        ext_x_reg        <= ext_x_next;
        ext_y_reg        <= ext_y_next;
    end

    always_comb
    begin
        cfg.scale        = scale_reg;
        cfg.inv_scale    = inv_scale_reg;
        cfg.view_left    = view_left_reg;
        cfg.view_top     = view_top_reg;
        cfg.log_bound_x  = log_bound_x_reg;
        cfg.log_bound_y  = log_bound_y_reg;
        cfg.phys_bound_x = phys_bound_x_reg;
        cfg.phys_bound_y = phys_bound_y_reg;
    end

    assign ext_x = ext_x_reg;
    assign ext_y = ext_y_reg;

endmodule

`default_nettype wire

### src/letterbox_coordinate_mapper.sv
// Letterbox coordinate mapper, top level: five-stage pipeline of multiply, round and clamp.
// Depends on lbcm_pkg, lbcm_req_if, lbcm_rsp_if and lbcm_config.
//
// Requests arrive on the req channel and each produces exactly one result on the rsp
// channel, in order. Both channels use valid and ready; a request is taken at a rising
// edge where both are high. Configuration registers are written through cfg_write,
// cfg_index and cfg_data, one register per cycle; the user must write them only while no
// request is in flight; the block does not enforce this. Stages: input register, product,
// offset and rounding add, clamp, output register. The four coordinate multipliers are
// pipelined, so while the receiver keeps ready high one request is accepted every cycle
// and throughput is one result per cycle. Reset clears every stage valid bit and loads
// the default frame geometry with unit scale factors. When the receiver holds ready low,
// the result waits in the output register while upstream stages keep filling; req.ready
// falls only once all five stages hold a request, and nothing is dropped or repeated.
`default_nettype none

module letterbox_coordinate_mapper #(
    parameter int COORD_BITS = lbcm_pkg::COORD_BITS_DEFAULT,
    parameter int FRAC_BITS  = lbcm_pkg::FRAC_BITS_DEFAULT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write,
    input  wire [lbcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [lbcm_pkg::CFG_DATA_W-1:0]     cfg_data,
    lbcm_req_if.sink                           req,
    lbcm_rsp_if.source                         rsp
);
    import lbcm_pkg::*;

    localparam int LANES = 4;
    localparam int AXES  = 2;
    localparam int OPW   = ((COORD_BITS > PHYS_W) ? COORD_BITS : PHYS_W) + 1;
    localparam int PW    = OPW + SCALE_W + 1;
    localparam int TW    = PW + 2;
    localparam int QW    = TW - FRAC_BITS;
    localparam int EXT_W = LOG_W + SCALE_W + 1 - FRAC_BITS;
    localparam int CMPW  = ((OPW > EXT_W) ? OPW : EXT_W) + 2;

    cfg_t             cfg;
    logic [EXT_W-1:0] ext_x;
    logic [EXT_W-1:0] ext_y;

    lbcm_config #(
        .FRAC_BITS (FRAC_BITS)
    ) u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .ext_x     (ext_x),
        .ext_y     (ext_y)
    );

    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic out_valid_reg;

    logic signed [COORD_BITS-1:0] coord [LANES];

    // Stage 1: operands.
    op_t                  s1_op_next;
    logic                 s1_phys_dir;
    logic [SCALE_W-1:0]   s1_scale_next;
    logic signed [OPW-1:0] s1_opnd_next [LANES];
    op_t                  s1_op_reg;
    logic [SCALE_W-1:0]   s1_scale_reg;
    logic signed [OPW-1:0] s1_opnd_reg [LANES];

    // Stage 2: products and viewport edge hits.
    logic signed [PW-1:0] s2_prod_next [LANES];
    logic                 s2_hit_near_next [AXES];
    logic                 s2_hit_far_next [AXES];
    op_t                  s2_op_reg;
    logic signed [PW-1:0] s2_prod_reg [LANES];
    logic                 s2_hit_near_reg [AXES];
    logic                 s2_hit_far_reg [AXES];

    // Stage 3: offset and rounding bias added.
    logic signed [TW-1:0] s3_t_next [LANES];
    op_t                  s3_op_reg;
    logic signed [TW-1:0] s3_t_reg [LANES];
    logic                 s3_hit_near_reg [AXES];
    logic                 s3_hit_far_reg [AXES];

    // Stage 4: clamped coordinates and virtual results.
    logic [OUT_W-1:0]     s4_res_next [LANES];
    logic [EXACT_W-1:0]   s4_exact_next [AXES];
    logic                 s4_low_next [AXES];
    logic                 s4_high_next [AXES];
    logic                 s4_inside_next;
    op_t                  s4_op_reg;
    logic [OUT_W-1:0]     s4_res_reg [LANES];
    logic [EXACT_W-1:0]   s4_exact_reg [AXES];
    logic                 s4_low_reg [AXES];
    logic                 s4_high_reg [AXES];
    logic                 s4_inside_reg;

    // Stage 5: output register.
    logic [OUT_W-1:0]     out_left_next;
    logic [OUT_W-1:0]     out_top_next;
    logic [OUT_W-1:0]     out_right_next;
    logic [OUT_W-1:0]     out_bottom_next;
    logic [EXACT_W-1:0]   exact_x_next;
    logic [EXACT_W-1:0]   exact_y_next;
    logic                 inside_next;
    logic                 low_x_next;
    logic                 high_x_next;
    logic                 low_y_next;
    logic                 high_y_next;
    op_t                  out_op_reg;
    logic [OUT_W-1:0]     out_left_reg;
    logic [OUT_W-1:0]     out_top_reg;
    logic [OUT_W-1:0]     out_right_reg;
    logic [OUT_W-1:0]     out_bottom_reg;
    logic [EXACT_W-1:0]   exact_x_reg;
    logic [EXACT_W-1:0]   exact_y_reg;
    logic                 inside_reg;
    logic                 low_x_reg;
    logic                 high_x_reg;
    logic                 low_y_reg;
    logic                 high_y_reg;

    assign en5 = !out_valid_reg || rsp.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign req.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= req.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    assign coord[0] = req.in_left;
    assign coord[1] = req.in_top;
    assign coord[2] = req.in_right;
    assign coord[3] = req.in_bottom;

    // Logical to physical multiplies the coordinate itself (right and bottom edges one
    // past); physical to logical multiplies the distance from the viewport edge.
    always_comb
    begin
        s1_op_next    = op_t'(req.operation);
        s1_phys_dir   = (s1_op_next == OP_LPOINT_TO_PHYS) || (s1_op_next == OP_LRECT_TO_PHYS);
        s1_scale_next = s1_phys_dir ? cfg.scale : cfg.inv_scale;
        for (int k = 0; k < LANES; k++)
        begin
            if (s1_phys_dir)
            begin
                s1_opnd_next[k] = OPW'(coord[k]) + ((k >= AXES) ? OPW'(1) : OPW'(0));
            end
            else
            begin
                s1_opnd_next[k] = OPW'(coord[k])
                    - OPW'(((k % AXES) == 0) ? cfg.view_left : cfg.view_top);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg    <= s1_op_next;
            s1_scale_reg <= s1_scale_next;
            for (int k = 0; k < LANES; k++)
            begin
                s1_opnd_reg[k] <= s1_opnd_next[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            s2_prod_next[k] = s1_opnd_reg[k] * $signed({1'b0, s1_scale_reg});
        end
        for (int j = 0; j < AXES; j++)
        begin
            s2_hit_near_next[j] = s1_opnd_reg[j] <= $signed(OPW'(0));
            s2_hit_far_next[j]  = ($signed(CMPW'(s1_opnd_reg[j])) + $signed(CMPW'(1)))
                >= $signed(CMPW'((j == 0) ? ext_x : ext_y));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_op_reg <= s1_op_reg;
            for (int k = 0; k < LANES; k++)
            begin
                s2_prod_reg[k] <= s2_prod_next[k];
            end
            for (int j = 0; j < AXES; j++)
            begin
                s2_hit_near_reg[j] <= s2_hit_near_next[j];
                s2_hit_far_reg[j]  <= s2_hit_far_next[j];
            end
        end
    end

    // The bias turns the following arithmetic shift into round half up, floor or ceil.
    always_comb
    begin
        logic [TW-1:0] addend;
        logic [TW-1:0] bias;
        for (int k = 0; k < LANES; k++)
        begin
            addend = '0;
            bias   = '0;
            case (s2_op_reg)
                OP_LPOINT_TO_PHYS:
                begin
                    addend = TW'(((k % AXES) == 0) ? cfg.view_left : cfg.view_top) << FRAC_BITS;
                    bias   = TW'(1) << (FRAC_BITS - 1);
                end
                OP_LRECT_TO_PHYS:
                begin
                    addend = TW'(((k % AXES) == 0) ? cfg.view_left : cfg.view_top) << FRAC_BITS;
                    bias   = (k >= AXES) ? ((TW'(1) << FRAC_BITS) - TW'(1)) : '0;
                end
                OP_PPOINT_TO_LOG, OP_PRECT_TO_LOG:
                begin
                    bias = TW'(1) << (FRAC_BITS - 1);
                end
                default:
                begin
                    bias = '0;
                end
            endcase
            s3_t_next[k] = TW'(s2_prod_reg[k]) + $signed(addend) + $signed(bias);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_op_reg <= s2_op_reg;
            for (int k = 0; k < LANES; k++)
            begin
                s3_t_reg[k] <= s3_t_next[k];
            end
            for (int j = 0; j < AXES; j++)
            begin
                s3_hit_near_reg[j] <= s2_hit_near_reg[j];
                s3_hit_far_reg[j]  <= s2_hit_far_reg[j];
            end
        end
    end

    always_comb
    begin
        logic signed [QW-1:0] q;
        logic [OUT_W-1:0]     bound;
        logic                 phys_dir;
        logic                 sub;
        logic [OUT_W-1:0]     lbound;
        logic [TW-1:0]        maxq;
        logic [TW-1:0]        e;
        phys_dir = (s3_op_reg == OP_LPOINT_TO_PHYS) || (s3_op_reg == OP_LRECT_TO_PHYS);
        for (int k = 0; k < LANES; k++)
        begin
            sub = (s3_op_reg == OP_LRECT_TO_PHYS) && (k >= AXES);
            if (phys_dir)
            begin
                bound = ((k % AXES) == 0) ? cfg.phys_bound_x : cfg.phys_bound_y;
            end
            else
            begin
                bound = ((k % AXES) == 0) ? cfg.log_bound_x : cfg.log_bound_y;
            end
            q = $signed(s3_t_reg[k][TW-1:FRAC_BITS]) - $signed(QW'(sub));
            if (q < $signed(QW'(0)))
            begin
                s4_res_next[k] = '0;
            end
            else if (q > $signed(QW'(bound)))
            begin
                s4_res_next[k] = bound;
            end
            else
            begin
                s4_res_next[k] = q[OUT_W-1:0];
            end
        end

        for (int j = 0; j < AXES; j++)
        begin
            lbound = (j == 0) ? cfg.log_bound_x : cfg.log_bound_y;
            maxq   = TW'(lbound) << FRAC_BITS;
            if (s3_t_reg[j] < $signed(TW'(0)))
            begin
                e = '0;
            end
            else if (s3_t_reg[j] > $signed(maxq))
            begin
                e = maxq;
            end
            else
            begin
                e = s3_t_reg[j];
            end
            s4_low_next[j]  = (s3_t_reg[j] <= $signed(TW'(0))) || (lbound == '0);
            s4_high_next[j] = (s3_t_reg[j] >= $signed(maxq)) || (lbound == '0);
            if (s3_hit_near_reg[j])
            begin
                e               = '0;
                s4_low_next[j]  = 1'b1;
                s4_high_next[j] = 1'b0;
            end
            else if (s3_hit_far_reg[j])
            begin
                e               = maxq;
                s4_low_next[j]  = 1'b0;
                s4_high_next[j] = 1'b1;
            end
            s4_exact_next[j] = e[EXACT_W-1:0];
        end

        s4_inside_next = !(s3_hit_near_reg[0] || s3_hit_far_reg[0]
            || s3_hit_near_reg[1] || s3_hit_far_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_op_reg     <= s3_op_reg;
            s4_inside_reg <= s4_inside_next;
            for (int k = 0; k < LANES; k++)
            begin
                s4_res_reg[k] <= s4_res_next[k];
            end
            for (int j = 0; j < AXES; j++)
            begin
                s4_exact_reg[j] <= s4_exact_next[j];
                s4_low_reg[j]   <= s4_low_next[j];
                s4_high_reg[j]  <= s4_high_next[j];
            end
        end
    end

    always_comb
    begin
        out_left_next   = '0;
        out_top_next    = '0;
        out_right_next  = '0;
        out_bottom_next = '0;
        exact_x_next    = '0;
        exact_y_next    = '0;
        inside_next     = 1'b0;
        low_x_next      = 1'b0;
        high_x_next     = 1'b0;
        low_y_next      = 1'b0;
        high_y_next     = 1'b0;
        case (s4_op_reg)
            OP_LPOINT_TO_PHYS, OP_PPOINT_TO_LOG:
            begin
                out_left_next = s4_res_reg[0];
                out_top_next  = s4_res_reg[1];
            end
            OP_LRECT_TO_PHYS:
            begin
                out_left_next   = (s4_res_reg[0] > s4_res_reg[2]) ? s4_res_reg[2] : s4_res_reg[0];
                out_top_next    = (s4_res_reg[1] > s4_res_reg[3]) ? s4_res_reg[3] : s4_res_reg[1];
                out_right_next  = s4_res_reg[2];
                out_bottom_next = s4_res_reg[3];
            end
            OP_PRECT_TO_LOG:
            begin
                out_left_next   = (s4_res_reg[0] < s4_res_reg[2]) ? s4_res_reg[0] : s4_res_reg[2];
                out_top_next    = (s4_res_reg[1] < s4_res_reg[3]) ? s4_res_reg[1] : s4_res_reg[3];
                out_right_next  = (s4_res_reg[0] > s4_res_reg[2]) ? s4_res_reg[0] : s4_res_reg[2];
                out_bottom_next = (s4_res_reg[1] > s4_res_reg[3]) ? s4_res_reg[1] : s4_res_reg[3];
            end
            OP_VIRTUAL_MAP:
            begin
                exact_x_next = s4_exact_reg[0];
                exact_y_next = s4_exact_reg[1];
                inside_next  = s4_inside_reg;
                low_x_next   = s4_low_reg[0];
                high_x_next  = s4_high_reg[0];
                low_y_next   = s4_low_reg[1];
                high_y_next  = s4_high_reg[1];
            end
            default:
            begin
                out_left_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            out_op_reg     <= s4_op_reg;
            out_left_reg   <= out_left_next;
            out_top_reg    <= out_top_next;
            out_right_reg  <= out_right_next;
            out_bottom_reg <= out_bottom_next;
            exact_x_reg    <= exact_x_next;
            exact_y_reg    <= exact_y_next;
            inside_reg     <= inside_next;
            low_x_reg      <= low_x_next;
            high_x_reg     <= high_x_next;
            low_y_reg      <= low_y_next;
            high_y_reg     <= high_y_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.out_left        = out_left_reg;
    assign rsp.out_top         = out_top_reg;
    assign rsp.out_right       = out_right_reg;
    assign rsp.out_bottom      = out_bottom_reg;
    assign rsp.exact_x         = exact_x_reg;
    assign rsp.exact_y         = exact_y_reg;
    assign rsp.inside_viewport = inside_reg;
    assign rsp.clamped_low_x   = low_x_reg;
    assign rsp.clamped_high_x  = high_x_reg;
    assign rsp.clamped_low_y   = low_y_reg;
    assign rsp.clamped_high_y  = high_y_reg;

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
            && out_valid_reg)
        else $error("request stalled while a pipeline stage was empty");

    a_rect_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (out_op_reg == OP_LRECT_TO_PHYS || out_op_reg == OP_PRECT_TO_LOG)
            |-> (rsp.out_left <= rsp.out_right) && (rsp.out_top <= rsp.out_bottom))
        else $error("rectangle result has inverted edges");

    a_point_no_far_edge: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (out_op_reg == OP_LPOINT_TO_PHYS || out_op_reg == OP_PPOINT_TO_LOG)
            |-> (rsp.out_right == '0) && (rsp.out_bottom == '0))
        else $error("point result carries a right or bottom coordinate");

    a_flags_only_virtual: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (out_op_reg != OP_VIRTUAL_MAP)
            |-> (rsp.exact_x == '0) && (rsp.exact_y == '0) && !rsp.inside_viewport
                && !rsp.clamped_low_x && !rsp.clamped_high_x
                && !rsp.clamped_low_y && !rsp.clamped_high_y)
        else $error("virtual mapping fields set outside virtual mode");
`endif

endmodule

`default_nettype wire
